// ===== src/mavg_pkg.sv =====
// Shared types and constants for the moving-average filter.
// Used by the controller, the datapath and the divider; depends on nothing.
package mavg_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int TAP_CFG_W = 11;
  localparam int TAP_RESET = 8;
  localparam int TAP_MIN   = 2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_START,
    ST_DIV,
    ST_SCAN_START,
    ST_SCAN,
    ST_SCAN_FINISH
  } mavg_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_in;      // latch request sample, read leaving entry
    logic update;       // update running sum, write history
    logic div_start;    // start divide of running sum by tap count
    logic load_out;     // load quotient into output register
    logic scan_clear;   // reset recompute accumulator and age counter
    logic scan_rd;      // read next history entry for recompute
    logic scan_finish;  // move accumulator into running sum
  } mavg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic scan_last;
  } mavg_status_t;

endpackage

// ===== src/mavg_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Result is saturated to the sample range. Depends on mavg_pkg.
module mavg_div
  import mavg_pkg::*;
#(
  parameter int SUM_W = 27,
  parameter int TAP_W = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [TAP_W-1:0]    divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [TAP_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [TAP_W-1:0] dvs;

  logic [TAP_W:0]   trial;
  logic             fits;
  logic [SUM_W-1:0] mag;
  logic             pos_ovf;
  logic             neg_ovf;

  // Magnitude of the dividend; the most negative value wraps to its own magnitude
  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Restoring division loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= mag;
      rem <= '0;
      dvs <= divisor;
      cnt <= CNT_W'(SUM_W);
    end else if (busy) begin
      rem <= fits ? trial[TAP_W-1:0] - dvs : trial[TAP_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Sign and saturation
  assign pos_ovf = |quo[SUM_W-1:SAMPLE_W-1];
  assign neg_ovf = pos_ovf && (quo != (SUM_W'(1) << (SAMPLE_W - 1)));

  always_comb begin
    if (neg) begin
      quotient = neg_ovf ? SAMPLE_MIN : -$signed(quo[SAMPLE_W-1:0]);
    end else begin
      quotient = pos_ovf ? SAMPLE_MAX : $signed(quo[SAMPLE_W-1:0]);
    end
  end

endmodule

// ===== src/mavg_datapath.sv =====
// Datapath: sample history memory, running sum, recompute accumulator,
// tap count register and output register. Depends on mavg_pkg and mavg_div.
module mavg_datapath
  import mavg_pkg::*;
#(
  parameter int MAX_TAPS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mavg_cmd_t                   cmd,
  output mavg_status_t                status,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic                        tap_count_we,
  input  logic        [TAP_CFG_W-1:0] tap_count,
  output logic signed [SAMPLE_W-1:0]  filtered_sample
);

  localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int SUM_W  = SAMPLE_W + 1 + ADDR_W;
  localparam int TAP_RST = (TAP_RESET > MAX_TAPS) ? MAX_TAPS : TAP_RESET;

  logic signed [SAMPLE_W-1:0] mem [MAX_TAPS];

  logic        [TAP_W-1:0]    tap;
  logic        [ADDR_W-1:0]   wr_pos;
  logic        [TAP_W-1:0]    fill;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    acc;
  logic        [TAP_W-1:0]    age_cnt;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       rd_valid;
  logic                       acc_en;

  logic        [TAP_W-1:0]    age;
  logic        [TAP_W:0]      addr_wide;
  logic        [ADDR_W-1:0]   rd_addr;
  logic signed [SAMPLE_W-1:0] term;
  logic signed [SUM_W-1:0]    acc_next;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] quotient;

  // Address of the entry written age samples ago, modulo the ring size
  assign age       = cmd.take_in ? tap : age_cnt;
  assign addr_wide = (TAP_W+1)'(wr_pos) + (TAP_W+1)'(MAX_TAPS) - (TAP_W+1)'(age);
  assign rd_addr   = (addr_wide >= (TAP_W+1)'(MAX_TAPS)) ?
                     ADDR_W'(addr_wide - (TAP_W+1)'(MAX_TAPS)) : ADDR_W'(addr_wide);

  // Entries never written read as zero
  assign term     = rd_valid ? rd_data : '0;
  assign acc_next = acc + SUM_W'(term);

  // History memory
  always_ff @(posedge clk) begin
    if (cmd.take_in || cmd.scan_rd) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.update) begin
      mem[wr_pos] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in || cmd.scan_rd) begin
      rd_valid <= age <= fill;
    end
    if (cmd.take_in) begin
      sample_q <= sample;
    end
  end

  // Tap count register, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= TAP_W'(TAP_RST);
    end else if (tap_count_we) begin
      if (tap_count < TAP_CFG_W'(TAP_MIN)) begin
        tap <= TAP_W'(TAP_MIN);
      end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
        tap <= TAP_W'(MAX_TAPS);
      end else begin
        tap <= TAP_W'(tap_count);
      end
    end
  end

  // Ring position, fill count and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      fill   <= '0;
      sum    <= '0;
    end else begin
      if (cmd.update) begin
        wr_pos <= (wr_pos == ADDR_W'(MAX_TAPS - 1)) ? '0 : wr_pos + ADDR_W'(1);
        if (fill != TAP_W'(MAX_TAPS)) begin
          fill <= fill + TAP_W'(1);
        end
        sum <= sum + SUM_W'(sample_q) - SUM_W'(term);
      end else if (cmd.scan_finish) begin
        sum <= acc_next;
      end
    end
  end

  // Recompute accumulator over the newest tap entries
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else if (cmd.scan_clear) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      acc     <= '0;
      age_cnt <= TAP_W'(1);
    end else begin
      if (acc_en) begin
        acc <= acc_next;
      end
      if (cmd.scan_rd) begin
        age_cnt <= age_cnt + TAP_W'(1);
      end
    end
  end

  mavg_div #(
    .SUM_W (SUM_W),
    .TAP_W (TAP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (tap),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered_sample <= quotient;
    end
  end

  assign status.div_done  = div_done;
  assign status.scan_last = age_cnt == tap;

endmodule

// ===== src/mavg_ctrl.sv =====
// Controller state machine: sequences sample requests, the divide and the
// sum recompute after a tap count write. Depends on mavg_pkg.
module mavg_ctrl
  import mavg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_stall,
  input  logic         tap_count_we,
  output logic         filtered_sample_valid,
  input  logic         filtered_sample_stall,
  input  mavg_status_t status,
  output mavg_cmd_t    cmd
);

  mavg_state_t state;
  mavg_state_t state_next;
  logic        out_free;

  assign out_free     = !filtered_sample_valid || !filtered_sample_stall;
  // A tap count write also holds off a request in its own cycle
  assign sample_stall = (state != ST_IDLE) || tap_count_we;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_sample_valid <= 1'b0;
    end else if (cmd.load_out) begin
      filtered_sample_valid <= 1'b1;
    end else if (!filtered_sample_stall) begin
      filtered_sample_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.update = 1'b1;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done && out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SCAN_START: begin
        cmd.scan_clear = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = ST_SCAN_FINISH;
        end
      end
      ST_SCAN_FINISH: begin
        cmd.scan_finish = 1'b1;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // A tap count write restarts the sum recompute
    if (tap_count_we) begin
      cmd        = '0;
      state_next = ST_SCAN_START;
    end
  end

endmodule

// ===== src/moving_average_filter.sv =====
// Moving-average filter top level: controller plus datapath.
// Depends on mavg_pkg, mavg_ctrl, mavg_datapath (and mavg_div below it).
//
//   channel    direction  handshake                     payload
//   sample     in         sample_valid / sample_stall   sample (s16)
//   filtered   out        filtered_sample_valid/_stall  filtered_sample (s16)
//   config     in         tap_count_we                  tap_count (u11)
//
// A sample steps through the read, update, divide-start and divide states,
// with the divider taking one bit per cycle of the SUM_W-bit running sum.
// A tap count write recomputes the sum through the single memory read port,
// reading the newest entries up to the clamped tap count one by one, during
// which sample_stall is high.
// No clearing pass after reset: a fill count marks unwritten history as zero.
// A waiting result in the output register does not block the next sample;
// only the final load waits for the output to drain.
module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int MAX_TAPS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  output logic signed [SAMPLE_W-1:0]  filtered_sample,
  output logic                        filtered_sample_valid,
  input  logic                        filtered_sample_stall,
  input  logic                        tap_count_we,
  input  logic        [TAP_CFG_W-1:0] tap_count
);

  mavg_cmd_t    cmd;
  mavg_status_t status;

  mavg_ctrl u_ctrl (
    .clk                   (clk),
    .rst                   (rst),
    .sample_valid          (sample_valid),
    .sample_stall          (sample_stall),
    .tap_count_we          (tap_count_we),
    .filtered_sample_valid (filtered_sample_valid),
    .filtered_sample_stall (filtered_sample_stall),
    .status                (status),
    .cmd                   (cmd)
  );

  mavg_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .sample          (sample),
    .tap_count_we    (tap_count_we),
    .tap_count       (tap_count),
    .filtered_sample (filtered_sample)
  );

endmodule

// ===== tb/tb_moving_average_filter.sv =====
// Self-checking testbench for moving_average_filter: streams samples with random
// idling on both sides, predicts each windowed mean and checks every output.
// Depends on mavg_pkg and the moving_average_filter RTL.
module tb_moving_average_filter;
  import mavg_pkg::*;

  localparam int MAX_TAPS       = 1024;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_REQUESTS = 133;
  localparam int LONG_HOLD_OFF  = 400;
  localparam int DRAIN_CYCLES   = 64;
  localparam int STUCK_LIMIT    = 20000;

  typedef enum logic {STEP_SAMPLE, STEP_TAPS} step_kind_t;

  // One directed step: a sample request or a tap count write
  typedef struct packed {
    step_kind_t                 kind;
    logic [SAMPLE_W-1:0]        value;
    logic                       known;  // mean typed in by hand
    logic signed [SAMPLE_W-1:0] mean;
  } step_t;

  // Directed steps; hand-typed means only where they are obvious
  localparam step_t DIRECTED_STEPS [26] = '{
    '{STEP_SAMPLE, SAMPLE_MAX,   1'b1, 16'sd4095},   // 32767 / 8
    '{STEP_SAMPLE, SAMPLE_MIN,   1'b1, 16'sd0},      // -1 / 8 truncates to zero
    '{STEP_SAMPLE, SAMPLE_MIN,   1'b1, -16'sd4096},  // -32769 / 8 toward zero
    '{STEP_TAPS,   16'd0,        1'b0, 16'sd0},      // below range, held at 2
    '{STEP_SAMPLE, SAMPLE_MIN,   1'b1, SAMPLE_MIN},  // two full-scale negatives
    '{STEP_SAMPLE, SAMPLE_MAX,   1'b1, 16'sd0},
    '{STEP_SAMPLE, SAMPLE_MAX,   1'b1, SAMPLE_MAX},  // two full-scale positives
    '{STEP_TAPS,   16'd1,        1'b0, 16'sd0},      // below range, held at 2
    '{STEP_SAMPLE, SAMPLE_MAX,   1'b1, SAMPLE_MAX},
    '{STEP_TAPS,   16'd2047,     1'b0, 16'sd0},      // above range, held at max
    '{STEP_SAMPLE, 16'd0,        1'b0, 16'sd0},
    '{STEP_SAMPLE, -16'sd1,      1'b0, 16'sd0},
    '{STEP_TAPS,   16'd1025,     1'b0, 16'sd0},      // just above range
    '{STEP_SAMPLE, 16'd12345,    1'b0, 16'sd0},
    '{STEP_TAPS,   16'd1024,     1'b0, 16'sd0},      // full window
    '{STEP_SAMPLE, SAMPLE_MIN,   1'b0, 16'sd0},
    '{STEP_TAPS,   16'd3,        1'b0, 16'sd0},      // mid-stream shrink
    '{STEP_SAMPLE, 16'd5,        1'b0, 16'sd0},
    '{STEP_SAMPLE, -16'sd7,      1'b0, 16'sd0},
    '{STEP_SAMPLE, -16'sd1,      1'b0, 16'sd0},
    '{STEP_TAPS,   16'd8,        1'b0, 16'sd0},      // back to the reset length
    '{STEP_SAMPLE, 16'h5555,     1'b0, 16'sd0},
    '{STEP_SAMPLE, 16'haaaa,     1'b0, 16'sd0},
    '{STEP_TAPS,   16'd2,        1'b0, 16'sd0},      // shortest window
    '{STEP_SAMPLE, 16'd1,        1'b0, 16'sd0},
    '{STEP_SAMPLE, -16'sd2,      1'b0, 16'sd0}       // -1 / 2 truncates to zero
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic                       filtered_sample_valid;
  logic                       filtered_sample_stall = 1'b0;
  logic                       tap_count_we = 1'b0;
  logic [TAP_CFG_W-1:0]       tap_count = TAP_CFG_W'(TAP_RESET);

  // Predicted filter state
  logic signed [SAMPLE_W-1:0] history_ring [MAX_TAPS] = '{default: '0};
  longint                     window_sum = 0;
  int                         ring_pos = 0;
  int                         window_len = TAP_RESET;

  logic signed [SAMPLE_W-1:0] expected_means [$];
  step_t                      directed_rows [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_requests = 0;
  int hold_offs_served = 0;
  int mismatches = 0;

  moving_average_filter #(.MAX_TAPS(MAX_TAPS)) DUT (
    .clk                   (clk),
    .rst                   (rst),
    .sample                (sample),
    .sample_valid          (sample_valid),
    .sample_stall          (sample_stall),
    .filtered_sample       (filtered_sample),
    .filtered_sample_valid (filtered_sample_valid),
    .filtered_sample_stall (filtered_sample_stall),
    .tap_count_we          (tap_count_we),
    .tap_count             (tap_count)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // New window length: clamp to TAP_MIN..MAX_TAPS, re-add the newest entries
  function automatic void retune_window(input logic [TAP_CFG_W-1:0] len);
    int k;
    if (len < TAP_MIN) window_len = TAP_MIN;
    else if (len > MAX_TAPS) window_len = MAX_TAPS;
    else window_len = int'(len);
    window_sum = 0;
    for (k = 1; k <= window_len; k++)
      window_sum += history_ring[(ring_pos + MAX_TAPS - k) % MAX_TAPS];
  endfunction

  // Slide the window by one sample and return the truncated, saturated mean
  function automatic logic signed [SAMPLE_W-1:0] window_mean_next(
    input logic signed [SAMPLE_W-1:0] x
  );
    longint mean;
    window_sum += longint'(x) -
                  longint'(history_ring[(ring_pos + MAX_TAPS - window_len) % MAX_TAPS]);
    history_ring[ring_pos] = x;
    ring_pos = (ring_pos + 1) % MAX_TAPS;
    mean = window_sum / longint'(window_len);
    if (mean > longint'(SAMPLE_MAX)) mean = SAMPLE_MAX;
    if (mean < longint'(SAMPLE_MIN)) mean = SAMPLE_MIN;
    return SAMPLE_W'(mean);
  endfunction

  // Predict on accepted requests, check accepted results in order
  always @(posedge clk) begin : score_results
    step_t                      row;
    logic signed [SAMPLE_W-1:0] mean;
    logic signed [SAMPLE_W-1:0] want;
    if (!rst) begin
      if (tap_count_we) retune_window(tap_count);
      if (sample_valid && !sample_stall) begin
        mean = window_mean_next(sample);
        if (directed_rows.size() != 0) begin
          row = directed_rows.pop_front();
          if (row.known) mean = row.mean;
        end
        expected_means.push_back(mean);
      end
      if (filtered_sample_valid && !filtered_sample_stall) begin
        if (expected_means.size() == 0) begin
          $error("filtered_sample: expected nothing, actual %0d", filtered_sample);
          mismatches++;
        end else begin
          want = expected_means.pop_front();
          if (filtered_sample !== want) begin
            $error("filtered_sample: expected %0d, actual %0d", want, filtered_sample);
            mismatches++;
          end
        end
      end
    end
  end

  // Output side: random stall, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_offs_served != hold_off_requests) begin
        filtered_sample_stall <= 1'b1;
        repeat (LONG_HOLD_OFF) @(posedge clk);
        hold_offs_served++;
      end
      filtered_sample_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Present one sample request, with random idle cycles ahead of it
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= x;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
  endtask

  // Stop sending and wait for every outstanding mean
  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (expected_means.size() != 0);
  endtask

  task automatic write_taps(input logic [TAP_CFG_W-1:0] len);
    wait_drained();
    tap_count    <= len;
    tap_count_we <= 1'b1;
    @(posedge clk);
    tap_count_we <= 1'b0;
  endtask

  // Stimulus: directed steps, then random phases with a new window each
  initial begin
    int                         phase;
    int                         n;
    logic [TAP_CFG_W-1:0]       len;
    logic signed [SAMPLE_W-1:0] x;
    do @(posedge clk); while (rst);
    send_idle_pct = 15;
    recv_idle_pct = 69;
    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == STEP_TAPS) begin
        write_taps(DIRECTED_STEPS[i].value[TAP_CFG_W-1:0]);
      end else begin
        directed_rows.push_back(DIRECTED_STEPS[i]);
        offer_sample(DIRECTED_STEPS[i].value);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // idle mix changes every third of the random part
      case (phase / 4)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // window length: mostly short, with extremes and out-of-range values
      case ($urandom_range(9))
        0: len = TAP_CFG_W'(MAX_TAPS);
        1: len = TAP_CFG_W'(TAP_MIN);
        2: len = TAP_CFG_W'($urandom_range(1));
        3: len = TAP_CFG_W'($urandom_range(2047, MAX_TAPS + 1));
        4, 5: len = TAP_CFG_W'($urandom_range(MAX_TAPS, 65));
        default: len = TAP_CFG_W'($urandom_range(64, 3));
      endcase
      write_taps(len);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        // long output hold-off while samples keep coming
        if (n == 20 && (phase == 1 || phase == 10)) hold_off_requests++;
        case ($urandom_range(7))
          0: x = SAMPLE_MAX;
          1: x = SAMPLE_MIN;
          2: x = SAMPLE_W'($urandom_range(32)) - 16'sd16;
          default: x = SAMPLE_W'($urandom());
        endcase
        offer_sample(x);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: too long with no request, result or register write
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || tap_count_we || (sample_valid && !sample_stall) ||
          (filtered_sample_valid && !filtered_sample_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mavg_pkg.sv
src/mavg_div.sv
src/mavg_datapath.sv
src/mavg_ctrl.sv
src/moving_average_filter.sv
tb/tb_moving_average_filter.sv
